// File: sv/swept_box_overlap_separate_defines.svh
// assertion helpers included by the sbos_checker file
`ifndef SWEPT_BOX_OVERLAP_SEPARATE_DEFINES_SVH
`define SWEPT_BOX_OVERLAP_SEPARATE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SBOS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbos assertion failed");

// next-cycle implication
`define SBOS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbos assertion failed");

`endif

// File: sv/sbos_pkg.sv
package sbos_pkg;

  localparam int unsigned BIAS_WIDTH = 16;
  localparam logic [BIAS_WIDTH-1:0] BIAS_RESET = 16'd1024;

  // flag bit positions
  localparam int unsigned FLAG_FIXED  = 0;
  localparam int unsigned FLAG_POS    = 1;
  localparam int unsigned FLAG_NEG    = 2;
  localparam int unsigned FLAG_ENTITY = 3;

  localparam int unsigned A_FLAGS_WIDTH = 3;
  localparam int unsigned B_FLAGS_WIDTH = 4;

  // touch codes
  localparam logic [1:0] TOUCH_NONE = 2'b00;
  localparam logic [1:0] TOUCH_POS  = 2'b01;
  localparam logic [1:0] TOUCH_NEG  = 2'b10;

  typedef struct packed {
    logic [1:0] a_touch;
    logic [1:0] b_touch;
    logic       separated;
  } sbos_status_t;

endpackage

// File: sv/sbos_resolve.sv
module sbos_resolve #(
  parameter int unsigned POSITION_WIDTH = 24,
  parameter int unsigned FRACTION_BITS  = 8,
  parameter int unsigned SIZE_WIDTH     = 12
) (
  input  logic signed [POSITION_WIDTH-1:0]           a_position_i,
  input  logic signed [POSITION_WIDTH-1:0]           a_last_position_i,
  input  logic        [SIZE_WIDTH-1:0]               a_size_along_i,
  input  logic signed [POSITION_WIDTH-1:0]           a_last_across_i,
  input  logic        [SIZE_WIDTH-1:0]               a_size_across_i,
  input  logic        [sbos_pkg::A_FLAGS_WIDTH-1:0]  a_flags_i,
  input  logic signed [POSITION_WIDTH-1:0]           b_position_i,
  input  logic signed [POSITION_WIDTH-1:0]           b_last_position_i,
  input  logic        [SIZE_WIDTH-1:0]               b_size_along_i,
  input  logic signed [POSITION_WIDTH-1:0]           b_last_across_i,
  input  logic        [SIZE_WIDTH-1:0]               b_size_across_i,
  input  logic        [sbos_pkg::B_FLAGS_WIDTH-1:0]  b_flags_i,
  input  logic        [sbos_pkg::BIAS_WIDTH-1:0]     push_margin_i,
  output logic signed [POSITION_WIDTH-1:0]           a_new_position_o,
  output logic signed [POSITION_WIDTH-1:0]           a_new_last_position_o,
  output logic signed [POSITION_WIDTH-1:0]           b_new_position_o,
  output logic signed [POSITION_WIDTH-1:0]           b_new_last_position_o,
  output sbos_pkg::sbos_status_t                     status_o
);

  localparam int unsigned SFX_WIDTH = SIZE_WIDTH + FRACTION_BITS;
  localparam int unsigned BASE_W0   = (POSITION_WIDTH > SFX_WIDTH) ? POSITION_WIDTH : SFX_WIDTH;
  localparam int unsigned BASE_W1   = (BASE_W0 > sbos_pkg::BIAS_WIDTH + 1) ?
                                      BASE_W0 : sbos_pkg::BIAS_WIDTH + 1;
  // headroom for motion sums doubled and for doubled overlaps
  localparam int unsigned W = BASE_W1 + 4;

  localparam logic signed [W-1:0] POS_MAX = {{(W-POSITION_WIDTH+1){1'b0}},
                                             {(POSITION_WIDTH-1){1'b1}}};
  localparam logic signed [W-1:0] POS_MIN = ~POS_MAX;

  function automatic logic signed [POSITION_WIDTH-1:0] sat(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = v;
    if (v > POS_MAX) r = POS_MAX;
    if (v < POS_MIN) r = POS_MIN;
    return r[POSITION_WIDTH-1:0];
  endfunction

  logic signed [W-1:0] ap, al, ax, bp, bl, bx;
  logic signed [W-1:0] aw, ah, bw, bh, bias;
  logic signed [W-1:0] d1, d2, d1a, d2a;
  logic signed [W-1:0] a_lo, a_hi, b_lo, b_hi;
  logic signed [W-1:0] lim2, pos_ov, neg_ov, pos_abs, neg_abs;
  logic signed [W-1:0] overlap, half, ap_n, al_n, bp_n, bl_n;
  logic                a_fixed, b_fixed, hit, pos_side, pos_ok, neg_ok;
  sbos_pkg::sbos_status_t st;

  assign ap   = W'(a_position_i);
  assign al   = W'(a_last_position_i);
  assign ax   = W'(a_last_across_i);
  assign bp   = W'(b_position_i);
  assign bl   = W'(b_last_position_i);
  assign bx   = W'(b_last_across_i);
  assign aw   = $signed(W'(a_size_along_i)) <<< FRACTION_BITS;
  assign ah   = $signed(W'(a_size_across_i)) <<< FRACTION_BITS;
  assign bw   = $signed(W'(b_size_along_i)) <<< FRACTION_BITS;
  assign bh   = $signed(W'(b_size_across_i)) <<< FRACTION_BITS;
  assign bias = $signed(W'(push_margin_i));

  assign a_fixed = a_flags_i[sbos_pkg::FLAG_FIXED];
  assign b_fixed = b_flags_i[sbos_pkg::FLAG_FIXED];

  assign d1  = ap - al;
  assign d2  = bp - bl;
  assign d1a = (d1 < 0) ? -d1 : d1;
  assign d2a = (d2 < 0) ? -d2 : d2;

  // swept extent runs from the lower of now/last to the higher plus size
  assign a_lo = (d1 > 0) ? al : ap;
  assign a_hi = ((d1 > 0) ? ap : al) + aw;
  assign b_lo = (d2 > 0) ? bl : bp;
  assign b_hi = ((d2 > 0) ? bp : bl) + bw;

  assign hit = (a_hi > b_lo) && (a_lo < b_hi) && (ax + ah > bx) && (ax < bx + bh);

  // limit kept doubled so a halved odd bias loses nothing
  assign lim2 = ((d1a + d2a) <<< 1) +
                (b_flags_i[sbos_pkg::FLAG_ENTITY] ? bias : (bias <<< 1));

  assign pos_ov  = ap + aw - bp;
  assign neg_ov  = ap - bw - bp;
  assign pos_abs = (pos_ov < 0) ? -pos_ov : pos_ov;
  assign neg_abs = (neg_ov < 0) ? -neg_ov : neg_ov;
  assign pos_side = pos_abs < neg_abs;

  assign pos_ok = !((pos_ov <<< 1) > lim2) && a_flags_i[sbos_pkg::FLAG_POS] &&
                  b_flags_i[sbos_pkg::FLAG_NEG];
  assign neg_ok = !(-(neg_ov <<< 1) > lim2) && a_flags_i[sbos_pkg::FLAG_NEG] &&
                  b_flags_i[sbos_pkg::FLAG_POS];

  always_comb begin
    st.a_touch   = sbos_pkg::TOUCH_NONE;
    st.b_touch   = sbos_pkg::TOUCH_NONE;
    st.separated = 1'b0;
    overlap      = '0;
    if (!(a_fixed && b_fixed) && hit) begin
      if (pos_side) begin
        if (pos_ok) begin
          overlap    = pos_ov;
          st.a_touch = sbos_pkg::TOUCH_POS;
          st.b_touch = sbos_pkg::TOUCH_NEG;
        end
      end else begin
        if (neg_ok) begin
          overlap    = neg_ov;
          st.a_touch = sbos_pkg::TOUCH_NEG;
          st.b_touch = sbos_pkg::TOUCH_POS;
        end
      end
    end
    st.separated = (overlap != '0);
  end

  assign half = overlap >>> 1;

  always_comb begin
    ap_n = ap;
    al_n = al;
    bp_n = bp;
    bl_n = bl;
    if (st.separated) begin
      if (!a_fixed && !b_fixed) begin
        ap_n = ap - half;
        bp_n = bp + half;
      end else if (!a_fixed) begin
        ap_n = ap - overlap;
        al_n = ap - overlap;
      end else begin
        bp_n = bp + overlap;
        bl_n = bp + overlap;
      end
    end
  end

  assign a_new_position_o      = sat(ap_n);
  assign a_new_last_position_o = sat(al_n);
  assign b_new_position_o      = sat(bp_n);
  assign b_new_last_position_o = sat(bl_n);
  assign status_o              = st;

endmodule

// File: sv/swept_box_overlap_separate.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+----------------------------------
// in       | input     | in_valid_i / in_stall_o | a_* and b_* box fields
// out      | output    | out_valid_o/out_stall_i | new positions, touches, separated
// cfg      | input     | cfg_we_i                | cfg_wdata_i (push margin)
//
// one box pair per cycle unless in_stall_o is high; a transaction taken sits in the input
// register, the resolve logic fills the output register from it when out can advance,
// which raises out_valid_o, and the result leaves from the output register
// the output register holds a stalled result while the input register may
// still take a transaction; in_stall_o rises only when both are full and out
// is stalled
// reset empties both stages and loads the push margin with its default of 1024
module swept_box_overlap_separate #(
  parameter int unsigned POSITION_WIDTH = 24,
  parameter int unsigned FRACTION_BITS  = 8,
  parameter int unsigned SIZE_WIDTH     = 12
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic        [sbos_pkg::BIAS_WIDTH-1:0]     cfg_wdata_i,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic signed [POSITION_WIDTH-1:0]           a_position_i,
  input  logic signed [POSITION_WIDTH-1:0]           a_last_position_i,
  input  logic        [SIZE_WIDTH-1:0]               a_size_along_i,
  input  logic signed [POSITION_WIDTH-1:0]           a_last_across_i,
  input  logic        [SIZE_WIDTH-1:0]               a_size_across_i,
  input  logic        [sbos_pkg::A_FLAGS_WIDTH-1:0]  a_flags_i,
  input  logic signed [POSITION_WIDTH-1:0]           b_position_i,
  input  logic signed [POSITION_WIDTH-1:0]           b_last_position_i,
  input  logic        [SIZE_WIDTH-1:0]               b_size_along_i,
  input  logic signed [POSITION_WIDTH-1:0]           b_last_across_i,
  input  logic        [SIZE_WIDTH-1:0]               b_size_across_i,
  input  logic        [sbos_pkg::B_FLAGS_WIDTH-1:0]  b_flags_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [POSITION_WIDTH-1:0]           a_new_position_o,
  output logic signed [POSITION_WIDTH-1:0]           a_new_last_position_o,
  output logic signed [POSITION_WIDTH-1:0]           b_new_position_o,
  output logic signed [POSITION_WIDTH-1:0]           b_new_last_position_o,
  output logic        [1:0]                          a_touch_o,
  output logic        [1:0]                          b_touch_o,
  output logic                                       separated_o
);

  logic [sbos_pkg::BIAS_WIDTH-1:0] bias_q;

  logic in_vld_d, in_vld_q, out_vld_d, out_vld_q;
  logic in_adv, out_adv;

  logic signed [POSITION_WIDTH-1:0]          ap_q, al_q, ax_q, bp_q, bl_q, bx_q;
  logic        [SIZE_WIDTH-1:0]              aw_q, ah_q, bw_q, bh_q;
  logic        [sbos_pkg::A_FLAGS_WIDTH-1:0] af_q;
  logic        [sbos_pkg::B_FLAGS_WIDTH-1:0] bf_q;

  logic signed [POSITION_WIDTH-1:0] ap_n, al_n, bp_n, bl_n;
  logic signed [POSITION_WIDTH-1:0] ap_o_q, al_o_q, bp_o_q, bl_o_q;
  sbos_pkg::sbos_status_t           st_n, st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= sbos_pkg::BIAS_RESET;
    end else if (cfg_we_i) begin
      bias_q <= cfg_wdata_i;
    end
  end

  assign out_adv   = !out_vld_q || !out_stall_i;
  assign in_adv    = !in_vld_q || out_adv;
  assign in_stall_o = !in_adv;

  assign in_vld_d  = in_adv ? in_valid_i : in_vld_q;
  assign out_vld_d = out_adv ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      ap_q <= a_position_i;
      al_q <= a_last_position_i;
      aw_q <= a_size_along_i;
      ax_q <= a_last_across_i;
      ah_q <= a_size_across_i;
      af_q <= a_flags_i;
      bp_q <= b_position_i;
      bl_q <= b_last_position_i;
      bw_q <= b_size_along_i;
      bx_q <= b_last_across_i;
      bh_q <= b_size_across_i;
      bf_q <= b_flags_i;
    end
  end

  sbos_resolve #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS),
    .SIZE_WIDTH     (SIZE_WIDTH)
  ) u_resolve (
    .a_position_i          (ap_q),
    .a_last_position_i     (al_q),
    .a_size_along_i        (aw_q),
    .a_last_across_i       (ax_q),
    .a_size_across_i       (ah_q),
    .a_flags_i             (af_q),
    .b_position_i          (bp_q),
    .b_last_position_i     (bl_q),
    .b_size_along_i        (bw_q),
    .b_last_across_i       (bx_q),
    .b_size_across_i       (bh_q),
    .b_flags_i             (bf_q),
    .push_margin_i         (bias_q),
    .a_new_position_o      (ap_n),
    .a_new_last_position_o (al_n),
    .b_new_position_o      (bp_n),
    .b_new_last_position_o (bl_n),
    .status_o              (st_n)
  );

  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      ap_o_q <= ap_n;
      al_o_q <= al_n;
      bp_o_q <= bp_n;
      bl_o_q <= bl_n;
      st_q   <= st_n;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign a_new_position_o      = ap_o_q;
  assign a_new_last_position_o = al_o_q;
  assign b_new_position_o      = bp_o_q;
  assign b_new_last_position_o = bl_o_q;
  assign a_touch_o             = st_q.a_touch;
  assign b_touch_o             = st_q.b_touch;
  assign separated_o           = st_q.separated;

endmodule

// File: sv/sbos_checker.sv
`include "swept_box_overlap_separate_defines.svh"

module sbos_checker #(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [POSITION_WIDTH-1:0] a_new_position_o,
  input logic signed [POSITION_WIDTH-1:0] a_new_last_position_o,
  input logic signed [POSITION_WIDTH-1:0] b_new_position_o,
  input logic signed [POSITION_WIDTH-1:0] b_new_last_position_o,
  input logic        [1:0]                a_touch_o,
  input logic        [1:0]                b_touch_o,
  input logic                             separated_o
);

  logic out_hold;
  logic touch_pair_ok;
  logic [4*POSITION_WIDTH+4:0] out_payload;

  assign out_hold = out_valid_o && out_stall_i;

  assign out_payload = {a_new_position_o, a_new_last_position_o, b_new_position_o,
                        b_new_last_position_o, a_touch_o, b_touch_o, separated_o};

  // while out_valid_o is high the two touch flags mirror each other
  assign touch_pair_ok =
    (a_touch_o == sbos_pkg::TOUCH_NONE && b_touch_o == sbos_pkg::TOUCH_NONE) ||
    (a_touch_o == sbos_pkg::TOUCH_POS  && b_touch_o == sbos_pkg::TOUCH_NEG) ||
    (a_touch_o == sbos_pkg::TOUCH_NEG  && b_touch_o == sbos_pkg::TOUCH_POS);

  `SBOS_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o && $stable(out_payload))

  `SBOS_ASSERT_SAME(a_touch_pair, out_valid_o, touch_pair_ok)

  `SBOS_ASSERT_SAME(a_sep_touch, out_valid_o && separated_o, a_touch_o != sbos_pkg::TOUCH_NONE)

  `SBOS_ASSERT_NEXT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i, out_valid_o)

endmodule

bind swept_box_overlap_separate sbos_checker #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_sbos_checker (.*);

// File: verif/separation_checker.sv
`timescale 1ns / 1ps

module separation_checker #(
  parameter int unsigned POS_W  = 24,
  parameter int unsigned FRAC_W = 8,
  parameter int unsigned SIZE_W = 12
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic        [sbos_pkg::BIAS_WIDTH-1:0]    cfg_wdata_i,
  input  logic                                      in_valid_i,
  input  logic                                      in_stall_i,
  input  logic signed [POS_W-1:0]                   a_position_i,
  input  logic signed [POS_W-1:0]                   a_last_position_i,
  input  logic        [SIZE_W-1:0]                  a_size_along_i,
  input  logic signed [POS_W-1:0]                   a_last_across_i,
  input  logic        [SIZE_W-1:0]                  a_size_across_i,
  input  logic        [sbos_pkg::A_FLAGS_WIDTH-1:0] a_flags_i,
  input  logic signed [POS_W-1:0]                   b_position_i,
  input  logic signed [POS_W-1:0]                   b_last_position_i,
  input  logic        [SIZE_W-1:0]                  b_size_along_i,
  input  logic signed [POS_W-1:0]                   b_last_across_i,
  input  logic        [SIZE_W-1:0]                  b_size_across_i,
  input  logic        [sbos_pkg::B_FLAGS_WIDTH-1:0] b_flags_i,
  input  logic                                      out_valid_i,
  input  logic                                      out_stall_i,
  input  logic signed [POS_W-1:0]                   a_new_position_i,
  input  logic signed [POS_W-1:0]                   a_new_last_position_i,
  input  logic signed [POS_W-1:0]                   b_new_position_i,
  input  logic signed [POS_W-1:0]                   b_new_last_position_i,
  input  logic        [1:0]                         a_touch_i,
  input  logic        [1:0]                         b_touch_i,
  input  logic                                      separated_i,
  output int                                        fail_count_o,
  output int                                        outstanding_o
);

  typedef struct packed {
    logic [POS_W-1:0] a_pos;
    logic [POS_W-1:0] a_last;
    logic [POS_W-1:0] b_pos;
    logic [POS_W-1:0] b_last;
    logic [1:0]       a_touch;
    logic [1:0]       b_touch;
    logic             separated;
  } separation_t;

  logic [sbos_pkg::BIAS_WIDTH-1:0] push_margin;
  separation_t                     expected_q[$];
  int                              fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input longint v);
    longint top_v;
    longint bot_v;
    top_v = (longint'(1) << (POS_W - 1)) - 1;
    bot_v = -top_v - 1;
    if (v > top_v) begin
      v = top_v;
    end else if (v < bot_v) begin
      v = bot_v;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic separation_t resolve_pair(
    input logic signed [POS_W-1:0]                   a_pos, a_last, a_across,
    input logic        [SIZE_W-1:0]                  a_len, a_depth,
    input logic        [sbos_pkg::A_FLAGS_WIDTH-1:0] a_fl,
    input logic signed [POS_W-1:0]                   b_pos, b_last, b_across,
    input logic        [SIZE_W-1:0]                  b_len, b_depth,
    input logic        [sbos_pkg::B_FLAGS_WIDTH-1:0] b_fl,
    input logic        [sbos_pkg::BIAS_WIDTH-1:0]    bias
  );
    longint ap, al, bp, bl, ax, bx, aw, ah, bw, bh;
    longint da, db, da_mag, db_mag, a_lo, a_hi, b_lo, b_hi;
    longint reach2, pos_ov, neg_ov, push, half;
    logic   a_fixed, b_fixed;
    separation_t r;
    ap = longint'(a_pos);
    al = longint'(a_last);
    ax = longint'(a_across);
    bp = longint'(b_pos);
    bl = longint'(b_last);
    bx = longint'(b_across);
    aw = longint'(a_len) << FRAC_W;
    ah = longint'(a_depth) << FRAC_W;
    bw = longint'(b_len) << FRAC_W;
    bh = longint'(b_depth) << FRAC_W;
    a_fixed = a_fl[sbos_pkg::FLAG_FIXED];
    b_fixed = b_fl[sbos_pkg::FLAG_FIXED];
    r.a_touch = sbos_pkg::TOUCH_NONE;
    r.b_touch = sbos_pkg::TOUCH_NONE;
    r.separated = 1'b0;
    push = 0;
    if (!(a_fixed && b_fixed)) begin
      da = ap - al;
      db = bp - bl;
      da_mag = magnitude(da);
      db_mag = magnitude(db);
      // swept extent covers both the last and the current position
      a_lo = (da > 0) ? al : ap;
      a_hi = a_lo + aw + da_mag;
      b_lo = (db > 0) ? bl : bp;
      b_hi = b_lo + bw + db_mag;
      if (a_hi > b_lo && a_lo < b_hi && ax + ah > bx && ax < bx + bh) begin
        // limit kept doubled so that half an odd bias is exact for entities
        reach2 = 2 * (da_mag + db_mag) + 2 * longint'(bias)
               - (b_fl[sbos_pkg::FLAG_ENTITY] ? longint'(bias) : longint'(0));
        pos_ov = ap + aw - bp;
        neg_ov = ap - bw - bp;
        if (magnitude(pos_ov) < magnitude(neg_ov)) begin
          if (2 * pos_ov <= reach2 && a_fl[sbos_pkg::FLAG_POS] && b_fl[sbos_pkg::FLAG_NEG]) begin
            push = pos_ov;
            r.a_touch = sbos_pkg::TOUCH_POS;
            r.b_touch = sbos_pkg::TOUCH_NEG;
          end
        end else if (-2 * neg_ov <= reach2 && a_fl[sbos_pkg::FLAG_NEG] &&
                     b_fl[sbos_pkg::FLAG_POS]) begin
          push = neg_ov;
          r.a_touch = sbos_pkg::TOUCH_NEG;
          r.b_touch = sbos_pkg::TOUCH_POS;
        end
      end
      if (push != 0) begin
        r.separated = 1'b1;
        if (!a_fixed && !b_fixed) begin
          half = push >>> 1;
          ap = ap - half;
          bp = bp + half;
        end else if (!a_fixed) begin
          ap = ap - push;
          al = ap;
        end else begin
          bp = bp + push;
          bl = bp;
        end
      end
    end
    r.a_pos = clamp_pos(ap);
    r.a_last = clamp_pos(al);
    r.b_pos = clamp_pos(bp);
    r.b_last = clamp_pos(bl);
    return r;
  endfunction

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : track_results
    separation_t want;
    if (!rst_ni) begin
      push_margin = sbos_pkg::BIAS_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        push_margin = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no input transaction outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("a_new_position", longint'($signed(want.a_pos)),
                        longint'(a_new_position_i));
          compare_field("a_new_last_position", longint'($signed(want.a_last)),
                        longint'(a_new_last_position_i));
          compare_field("b_new_position", longint'($signed(want.b_pos)),
                        longint'(b_new_position_i));
          compare_field("b_new_last_position", longint'($signed(want.b_last)),
                        longint'(b_new_last_position_i));
          compare_field("a_touch", longint'(want.a_touch), longint'(a_touch_i));
          compare_field("b_touch", longint'(want.b_touch), longint'(b_touch_i));
          compare_field("separated", longint'(want.separated), longint'(separated_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(resolve_pair(
          a_position_i, a_last_position_i, a_last_across_i,
          a_size_along_i, a_size_across_i, a_flags_i,
          b_position_i, b_last_position_i, b_last_across_i,
          b_size_along_i, b_size_across_i, b_flags_i, push_margin));
      end
    end
    outstanding_o <= expected_q.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int POS_W           = 24;
  localparam int FRAC_W          = 8;
  localparam int SIZE_W          = 12;
  localparam int AF_W            = sbos_pkg::A_FLAGS_WIDTH;
  localparam int BF_W            = sbos_pkg::B_FLAGS_WIDTH;
  localparam int BIAS_W          = sbos_pkg::BIAS_WIDTH;
  localparam int PX              = 1 << FRAC_W;
  localparam int POS_MAX         = (1 << (POS_W - 1)) - 1;
  localparam int POS_MIN         = -POS_MAX - 1;
  localparam int STALL_LIMIT     = 20000;
  localparam int PAIRS_PER_PHASE = 305;
  localparam int BIAS_PHASES     = 6;

  localparam int F_FIX = 1 << sbos_pkg::FLAG_FIXED;
  localparam int F_POS = 1 << sbos_pkg::FLAG_POS;
  localparam int F_NEG = 1 << sbos_pkg::FLAG_NEG;
  localparam int F_ENT = 1 << sbos_pkg::FLAG_ENTITY;
  localparam int MV    = F_POS | F_NEG;
  localparam int FX    = F_FIX | MV;

  typedef struct {
    logic [POS_W-1:0]  a_pos;
    logic [POS_W-1:0]  a_last;
    logic [SIZE_W-1:0] a_len;
    logic [POS_W-1:0]  a_across;
    logic [SIZE_W-1:0] a_depth;
    logic [AF_W-1:0]   a_flags;
    logic [POS_W-1:0]  b_pos;
    logic [POS_W-1:0]  b_last;
    logic [SIZE_W-1:0] b_len;
    logic [POS_W-1:0]  b_across;
    logic [SIZE_W-1:0] b_depth;
    logic [BF_W-1:0]   b_flags;
  } box_pair_t;

  logic                      clk_i             = 1'b0;
  logic                      rst_ni            = 1'b0;
  logic                      cfg_we_i          = 1'b0;
  logic [BIAS_W-1:0]         cfg_wdata_i       = '0;
  logic                      in_valid_i        = 1'b0;
  logic signed [POS_W-1:0]   a_position_i      = '0;
  logic signed [POS_W-1:0]   a_last_position_i = '0;
  logic [SIZE_W-1:0]         a_size_along_i    = '0;
  logic signed [POS_W-1:0]   a_last_across_i   = '0;
  logic [SIZE_W-1:0]         a_size_across_i   = '0;
  logic [AF_W-1:0]           a_flags_i         = '0;
  logic signed [POS_W-1:0]   b_position_i      = '0;
  logic signed [POS_W-1:0]   b_last_position_i = '0;
  logic [SIZE_W-1:0]         b_size_along_i    = '0;
  logic signed [POS_W-1:0]   b_last_across_i   = '0;
  logic [SIZE_W-1:0]         b_size_across_i   = '0;
  logic [BF_W-1:0]           b_flags_i         = '0;
  logic                      out_stall_i       = 1'b0;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic signed [POS_W-1:0]   a_new_position_o;
  logic signed [POS_W-1:0]   a_new_last_position_o;
  logic signed [POS_W-1:0]   b_new_position_o;
  logic signed [POS_W-1:0]   b_new_last_position_o;
  logic [1:0]                a_touch_o;
  logic [1:0]                b_touch_o;
  logic                      separated_o;

  int fail_count;
  int outstanding;
  int send_idle_pct  = 12;
  int recv_stall_pct = 47;
  int quiet_cycles   = 0;

  swept_box_overlap_separate #(
    .POSITION_WIDTH (POS_W),
    .FRACTION_BITS  (FRAC_W),
    .SIZE_WIDTH     (SIZE_W)
  ) u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .a_position_i          (a_position_i),
    .a_last_position_i     (a_last_position_i),
    .a_size_along_i        (a_size_along_i),
    .a_last_across_i       (a_last_across_i),
    .a_size_across_i       (a_size_across_i),
    .a_flags_i             (a_flags_i),
    .b_position_i          (b_position_i),
    .b_last_position_i     (b_last_position_i),
    .b_size_along_i        (b_size_along_i),
    .b_last_across_i       (b_last_across_i),
    .b_size_across_i       (b_size_across_i),
    .b_flags_i             (b_flags_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .a_new_position_o      (a_new_position_o),
    .a_new_last_position_o (a_new_last_position_o),
    .b_new_position_o      (b_new_position_o),
    .b_new_last_position_o (b_new_last_position_o),
    .a_touch_o             (a_touch_o),
    .b_touch_o             (b_touch_o),
    .separated_o           (separated_o)
  );

  separation_checker #(
    .POS_W  (POS_W),
    .FRAC_W (FRAC_W),
    .SIZE_W (SIZE_W)
  ) u_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .a_position_i          (a_position_i),
    .a_last_position_i     (a_last_position_i),
    .a_size_along_i        (a_size_along_i),
    .a_last_across_i       (a_last_across_i),
    .a_size_across_i       (a_size_across_i),
    .a_flags_i             (a_flags_i),
    .b_position_i          (b_position_i),
    .b_last_position_i     (b_last_position_i),
    .b_size_along_i        (b_size_along_i),
    .b_last_across_i       (b_last_across_i),
    .b_size_across_i       (b_size_across_i),
    .b_flags_i             (b_flags_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .a_new_position_i      (a_new_position_o),
    .a_new_last_position_i (a_new_last_position_o),
    .b_new_position_i      (b_new_position_o),
    .b_new_last_position_i (b_new_last_position_o),
    .a_touch_i             (a_touch_o),
    .b_touch_i             (b_touch_o),
    .separated_i           (separated_o),
    .fail_count_o          (fail_count),
    .outstanding_o         (outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("no transaction for %0d cycles, giving up", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic box_pair_t make_pair(input int ap, al, aw, ax, ah, af,
                                          input int bp, bl, bw, bx, bh, bf);
    box_pair_t p;
    p.a_pos    = ap[POS_W-1:0];
    p.a_last   = al[POS_W-1:0];
    p.a_len    = aw[SIZE_W-1:0];
    p.a_across = ax[POS_W-1:0];
    p.a_depth  = ah[SIZE_W-1:0];
    p.a_flags  = af[AF_W-1:0];
    p.b_pos    = bp[POS_W-1:0];
    p.b_last   = bl[POS_W-1:0];
    p.b_len    = bw[SIZE_W-1:0];
    p.b_across = bx[POS_W-1:0];
    p.b_depth  = bh[SIZE_W-1:0];
    p.b_flags  = bf[BF_W-1:0];
    return p;
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t p;
    int kind, a_len, b_len, a_dep, b_dep, ap, bp, ax, swing;
    kind = $urandom_range(99);
    if (kind < 15) begin
      // raw noise over every field
      p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      if (kind < 30) begin
        // big boxes with long sweeps near either end of the range, to hit saturation
        a_len = $urandom_range(2048, 4095);
        b_len = $urandom_range(2048, 4095);
        a_dep = $urandom_range(0, 4095);
        b_dep = $urandom_range(0, 4095);
        ap = $urandom_range(1) ? POS_MAX - int'($urandom_range(0, 1 << 21))
                               : POS_MIN + int'($urandom_range(0, 1 << 21));
        swing = 1 << 23;
      end else begin
        a_len = ($urandom_range(99) < 85) ? $urandom_range(0, 48) : $urandom_range(0, 4095);
        b_len = ($urandom_range(99) < 85) ? $urandom_range(0, 48) : $urandom_range(0, 4095);
        a_dep = ($urandom_range(99) < 85) ? $urandom_range(0, 48) : $urandom_range(0, 4095);
        b_dep = ($urandom_range(99) < 85) ? $urandom_range(0, 48) : $urandom_range(0, 4095);
        ap = int'($urandom) >>> 8;
        swing = ($urandom_range(99) < 85) ? 16 * PX : 512 * PX;
      end
      bp = ap + int'($urandom_range(0, (a_len + b_len + 8) * PX)) - (b_len + 4) * PX;
      ax = int'($urandom) >>> 8;
      p = make_pair(ap, ap - int'($urandom_range(0, swing)) + swing / 2, a_len,
                    ax, a_dep, $urandom,
                    bp, bp - int'($urandom_range(0, swing)) + swing / 2, b_len,
                    ax + int'($urandom_range(0, (a_dep + b_dep + 2) * PX)) - (b_dep + 1) * PX,
                    b_dep, $urandom);
      if ($urandom_range(3) == 0) begin
        p.a_last = p.a_pos;
      end
      if ($urandom_range(3) == 0) begin
        p.b_last = p.b_pos;
      end
      if ($urandom_range(99) < 65) begin
        p.a_flags = p.a_flags | AF_W'(MV);
        p.b_flags = p.b_flags | BF_W'(MV);
      end
    end
    return p;
  endfunction

  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    a_position_i      <= p.a_pos;
    a_last_position_i <= p.a_last;
    a_size_along_i    <= p.a_len;
    a_last_across_i   <= p.a_across;
    a_size_across_i   <= p.a_depth;
    a_flags_i         <= p.a_flags;
    b_position_i      <= p.b_pos;
    b_last_position_i <= p.b_last;
    b_size_along_i    <= p.b_len;
    b_last_across_i   <= p.b_across;
    b_size_across_i   <= p.b_depth;
    b_flags_i         <= p.b_flags;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold the input side until every outstanding result is back, then let the pipe settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bias(input logic [BIAS_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    box_pair_t         directed_q[$];
    logic [BIAS_W-1:0] bias_plan[BIAS_PHASES];
    int                random_count;
    int unsigned       draw;
    bias_plan[0] = '0;
    bias_plan[1] = '1;
    bias_plan[2] = 16'd1;
    bias_plan[3] = 16'd1025;
    draw = $urandom;
    bias_plan[4] = draw[BIAS_W-1:0];
    draw = $urandom | 1;
    bias_plan[5] = draw[BIAS_W-1:0];
    random_count = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs at the reset bias of four pixels
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, FX, 5*PX, 5*PX, 10, 0, 10, FX));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 100*PX, 100*PX, 10, 0, 10, MV));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 5*PX, 5*PX, 10, 10*PX, 10, MV));
    // odd overlaps on each side, halved between movable boxes
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 10*PX-3, 10*PX-3, 10, 3*PX, 10, MV));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, -10*PX+3, -10*PX+3, 10, 0, 10, MV));
    // one box immovable, the other takes the whole push and snaps its last position
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, FX, 10*PX-3, 10*PX-3, 10, 0, 10, MV));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, -10*PX+3, -10*PX+3, 10, 0, 10, FX));
    // equal overlaps on both sides go negative
    directed_q.push_back(make_pair(0, 2000, 10, 0, 10, MV, 0, 0, 10, 0, 10, MV));
    // just touching: flags set, nothing moves
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 10*PX, 9*PX, 10, 0, 10, MV));
    // over and exactly at the bias limit, then the halved limit for entities
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 10*PX-1100, 10*PX-1100, 10, 0, 10, MV));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 10*PX-1024, 10*PX-1024, 10, 0, 10, MV));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 10*PX-512, 10*PX-512, 10, 0, 10,
                                   MV | F_ENT));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 10*PX-513, 10*PX-513, 10, 0, 10,
                                   MV | F_ENT));
    // contact refused by either side
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, F_NEG, 10*PX-3, 10*PX-3, 10, 0, 10, MV));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, MV, 10*PX-3, 10*PX-3, 10, 0, 10, F_POS));
    directed_q.push_back(make_pair(0, 0, 10, 0, 10, F_POS, -10*PX+3, -10*PX+3, 10, 0, 10, MV));
    // pushed past either end of the position range
    directed_q.push_back(make_pair(POS_MIN+680, POS_MIN+680+1100000, 4095, 0, 10, MV,
                                   POS_MIN+1000, POS_MIN+1000, 4095, 0, 10, FX));
    directed_q.push_back(make_pair(POS_MAX-1000, POS_MAX-1000, 4095, 0, 10, FX,
                                   POS_MAX-680, POS_MAX-680-1100000, 4095, 0, 10, MV));
    // field extremes
    directed_q.push_back(make_pair(POS_MAX, POS_MIN, 4095, POS_MAX, 4095, 7,
                                   POS_MAX, POS_MIN, 4095, POS_MAX, 4095, 15));
    directed_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_pair(POS_MIN, POS_MAX, 4095, POS_MIN, 4095, MV,
                                   POS_MAX, POS_MIN, 4095, POS_MIN, 4095, MV | F_ENT));
    foreach (directed_q[i]) begin
      send_pair(directed_q[i]);
    end
    wait_drained();

    for (int phase = 0; phase < BIAS_PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct  = 12;
        recv_stall_pct = 47;
      end else if (phase < 4) begin
        send_idle_pct  = 47;
        recv_stall_pct = 12;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_bias(bias_plan[phase]);
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        if (n == PAIRS_PER_PHASE / 2 && phase % 2 == 1) begin
          wait_drained();
        end
        send_pair(random_pair());
        random_count++;
      end
      wait_drained();
    end

    $display("ran %0d directed and %0d random box pairs through %0d push margin values",
             directed_q.size(), random_count, BIAS_PHASES + 1);
    $display("with idling on the input side, the output side and neither");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
